// File: rtl/lzw_pkg.sv
// Package for the LZW byte compressor: widths, dictionary entry type,
// controller states and the slot hash. No dependencies.
package lzw_pkg;

    localparam int CODE_BITS    = 12;
    localparam int BYTE_W       = 8;
    localparam int CODE_FIELD_W = 12;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;
    localparam int TABLE_DEPTH  = 1 << CODE_BITS;

    typedef logic [CODE_BITS-1:0] code_t;
    typedef logic [CODE_BITS:0]   free_t;
    typedef logic [BYTE_W-1:0]    byte_t;

    localparam free_t FIRST_FREE = free_t'(256);

    typedef struct packed {
        code_t prefix;
        byte_t data;
        code_t slot;
    } dict_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DICT,
        ST_CHECK,
        ST_EMIT_PREFIX,
        ST_EMIT_LAST
    } state_t;

    function automatic code_t slot_hash(input code_t prefix, input byte_t data);
        return prefix ^ {data, {(CODE_BITS-BYTE_W){1'b0}}};
    endfunction

endpackage

// File: rtl/lzw_byte_compressor.sv
// LZW byte compressor top level: hashed dictionary in two synchronous RAMs.
// Depends on lzw_pkg.
//
// Bytes in on s_*, 12-bit LZW codes out on m_*. s_tlast marks the final byte
// of a stream; the final code carries m_tlast and the dictionary then starts
// empty for the next stream. One byte is handled at a time. The first byte of
// a stream is taken without a probe; every later byte is accepted and probes
// the slot table, each probe a slot RAM read, a code RAM read and a compare;
// a probe chain is usually one slot long and grows on hash collisions as
// the table fills. Each emitted code waits while the output word is held
// by m_tready. Both RAMs have 4096 entries; no clearing pass is needed,
// a slot counts only if the code it names is live and points back to it.
module lzw_byte_compressor
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lzw_pkg::IN_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // end_of_stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lzw_pkg::OUT_TDATA_W-1:0] m_tdata,  // [11:0] code, [15:12] zero
    output logic                           m_tlast    // last_code
);
    import lzw_pkg::*;

    state_t state_reg, state_next;
    code_t  prefix_reg, prefix_next;
    logic   prefix_valid_reg, prefix_valid_next;
    free_t  next_free_reg, next_free_next;
    byte_t  byte_reg, byte_next;
    logic   eos_reg, eos_next;
    code_t  slot_reg, slot_next;
    logic   m_valid_reg, m_valid_next;
    logic [CODE_FIELD_W-1:0] m_code_reg, m_code_next;
    logic   m_last_reg, m_last_next;

    code_t       slot_mem [TABLE_DEPTH];
    dict_entry_t dict_mem [TABLE_DEPTH];
    code_t       slot_q;
    dict_entry_t dict_q;

    logic  ins_en;
    logic  out_free;
    logic  live;
    logic  key_hit;
    logic  table_full;

    assign out_free   = !m_valid_reg || m_tready;
    assign table_full = next_free_reg[CODE_BITS];
    assign live       = (free_t'(slot_q) >= FIRST_FREE) && (free_t'(slot_q) < next_free_reg)
                        && (dict_q.slot == slot_reg);
    assign key_hit    = (dict_q.prefix == prefix_reg) && (dict_q.data == byte_reg);

    always_ff @(posedge clk)
    begin
        slot_q <= slot_mem[slot_reg];
        dict_q <= dict_mem[slot_q];
    end

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            slot_mem[slot_reg] <= next_free_reg[CODE_BITS-1:0];
            dict_mem[next_free_reg[CODE_BITS-1:0]] <= '{prefix: prefix_reg, data: byte_reg,
                                                        slot: slot_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= FIRST_FREE;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        eos_reg    <= eos_next;
        slot_reg   <= slot_next;
        m_code_reg <= m_code_next;
        m_last_reg <= m_last_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        byte_next         = byte_reg;
        eos_next          = eos_reg;
        slot_next         = slot_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_code_next       = m_code_reg;
        m_last_next       = m_last_reg;
        ins_en            = 1'b0;
        s_tready          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    byte_next = s_tdata[BYTE_W-1:0];
                    eos_next  = s_tlast;
                    if (!prefix_valid_reg)
                    begin
                        prefix_next       = code_t'(s_tdata[BYTE_W-1:0]);
                        prefix_valid_next = 1'b1;
                        state_next        = s_tlast ? ST_EMIT_LAST : ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_hash(prefix_reg, s_tdata[BYTE_W-1:0]);
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_DICT;
            end
            ST_DICT:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (live && key_hit)
                begin
                    prefix_next = slot_q;
                    state_next  = eos_reg ? ST_EMIT_LAST : ST_IDLE;
                end
                else if (live)
                begin
                    slot_next  = slot_reg + code_t'(1);
                    state_next = ST_LOOKUP;
                end
                else
                begin
                    if (!table_full)
                    begin
                        ins_en         = 1'b1;
                        next_free_next = next_free_reg + free_t'(1);
                    end
                    state_next = ST_EMIT_PREFIX;
                end
            end
            ST_EMIT_PREFIX:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_code_next  = CODE_FIELD_W'(prefix_reg);
                    m_last_next  = 1'b0;
                    prefix_next  = code_t'(byte_reg);
                    state_next   = eos_reg ? ST_EMIT_LAST : ST_IDLE;
                end
            end
            ST_EMIT_LAST:
            begin
                if (out_free)
                begin
                    m_valid_next      = 1'b1;
                    m_code_next       = CODE_FIELD_W'(prefix_reg);
                    m_last_next       = 1'b1;
                    prefix_next       = '0;
                    prefix_valid_next = 1'b0;
                    next_free_next    = FIRST_FREE;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_code_reg);
    assign m_tlast  = m_last_reg;

endmodule

// File: rtl/lzw_chk.sv
// Port-level checker for the LZW byte compressor, bound to the top level.
// Depends on lzw_pkg for port widths.
module lzw_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [lzw_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lzw_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import lzw_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:CODE_FIELD_W] == '0)
        else $error("code padding bits not zero");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("new byte taken before final code was issued");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind lzw_byte_compressor lzw_chk u_lzw_chk (.*);

// File: tb/sv/lzw_byte_compressor_chk.sv
`timescale 1ns / 1ps
// Checker for lzw_byte_compressor: watches both stream channels, predicts the LZW codes
// from accepted bytes and compares every output word. Depends on lzw_pkg.
module lzw_byte_compressor_chk
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lzw_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lzw_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    output int                              mismatches,
    output int                              pending,
    output int                              bytes_in,
    output int                              codes_out,
    output int                              streams_done,
    output int                              full_bytes
);
    import lzw_pkg::*;

    localparam int MAX_PRINTS = 40;

    typedef logic [CODE_BITS+BYTE_W-1:0] pair_key_t;

    typedef struct {
        logic [CODE_FIELD_W-1:0] code;
        logic                    last;
    } code_word_t;

    code_word_t expected_codes[$];
    code_t      pair_code[pair_key_t];
    free_t      next_code   = FIRST_FREE;
    code_t      cur_prefix  = '0;
    logic       have_prefix = 1'b0;

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        bytes_in     = 0;
        codes_out    = 0;
        streams_done = 0;
        full_bytes   = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: code word %0d: %s got 0x%0h, want 0x%0h",
                     $time, codes_out, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_dictionary();
        pair_code.delete();
        next_code   = FIRST_FREE;
        cur_prefix  = '0;
        have_prefix = 1'b0;
    endfunction

    function automatic void expect_word(input code_t c, input logic last);
        code_word_t w;
        w.code = CODE_FIELD_W'(c);
        w.last = last;
        expected_codes.insert(expected_codes.size(), w);
    endfunction

    function automatic void predict_codes(input byte_t b, input logic eos);
        pair_key_t key;
        key = {cur_prefix, b};
        if (next_code == free_t'(TABLE_DEPTH))
            full_bytes++;
        if (!have_prefix)
        begin
            cur_prefix  = code_t'(b);
            have_prefix = 1'b1;
        end
        else if (pair_code.exists(key))
            cur_prefix = pair_code[key];
        else
        begin
            expect_word(cur_prefix, 1'b0);
            if (next_code < free_t'(TABLE_DEPTH))
            begin
                pair_code[key] = code_t'(next_code);
                next_code++;
            end
            cur_prefix = code_t'(b);
        end
        if (eos)
        begin
            expect_word(cur_prefix, 1'b1);
            clear_dictionary();
            streams_done++;
        end
    endfunction

    always @(posedge clk)
    begin
        code_word_t want;
        if (!rst_n)
        begin
            clear_dictionary();
            expected_codes.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_codes(s_tdata[BYTE_W-1:0], s_tlast);
                bytes_in++;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_codes.size() == 0)
                    report_mismatch("unexpected word, code", int'(m_tdata), 0);
                else
                begin
                    want = expected_codes.pop_front();
                    if (m_tdata[CODE_FIELD_W-1:0] !== want.code)
                        report_mismatch("code", int'(m_tdata[CODE_FIELD_W-1:0]),
                                        int'(want.code));
                    if (m_tlast !== want.last)
                        report_mismatch("tlast", int'(m_tlast), int'(want.last));
                    if (m_tdata[OUT_TDATA_W-1:CODE_FIELD_W] !== '0)
                        report_mismatch("pad bits",
                                        int'(m_tdata[OUT_TDATA_W-1:CODE_FIELD_W]), 0);
                end
                codes_out++;
            end
        end
        pending = expected_codes.size();
    end

endmodule

// File: tb/sv/lzw_byte_compressor_tb.sv
`timescale 1ns / 1ps
// Testbench top for lzw_byte_compressor: drives byte streams with bursty pacing and
// output stalls, and gives the verdict. Depends on lzw_pkg and lzw_byte_compressor_chk.
module lzw_byte_compressor_tb;
    import lzw_pkg::*;

    localparam int RANDOM_BYTES = 800;
    localparam int LONG_STREAM  = 1000;
    localparam int DRAIN_CYCLES = 2000;

    typedef enum int { SRC_FULL, SRC_FEW, SRC_RUN } source_t;
    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED } rx_mode_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int mismatches, pending, bytes_in, codes_out, streams_done, full_bytes;
    int burst_left = 1;
    int random_sent = 0;

    lzw_byte_compressor DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    lzw_byte_compressor_chk u_chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .pending      (pending),
        .bytes_in     (bytes_in),
        .codes_out    (codes_out),
        .streams_done (streams_done),
        .full_bytes   (full_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("timeout: %0d words still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver stalls
    initial
    begin
        rx_mode_t mode;
        int       span;
        logic     ready;
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(32, 400);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    RX_OPEN:   ready = 1'b1;
                    RX_COIN:   ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: ready = ($urandom_range(0, 3) == 0);
                    default:   ready = ($urandom_range(0, 31) == 0);
                endcase
                m_tready <= ready;
            end
        end
    end

    task automatic put_byte(input byte_t b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic send_stream(input int len, input source_t src);
        byte_t base, b;
        int    span;
        base = byte_t'($urandom_range(0, 255));
        span = $urandom_range(2, 6);
        for (int i = 0; i < len; i++)
        begin
            case (src)
                SRC_FULL: b = byte_t'($urandom_range(0, 255));
                SRC_FEW:  b = base + byte_t'($urandom_range(0, span - 1));
                default:  b = ($urandom_range(0, 7) == 0) ? byte_t'($urandom_range(0, 255))
                                                          : base;
            endcase
            put_byte(b, i == len - 1);
        end
    endtask

    initial
    begin
        int      len;
        source_t src;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte streams
        put_byte(8'h00, 1'b1);
        put_byte(8'hFF, 1'b1);
        // repeated byte: prefix grows, ends on a hit
        for (int i = 0; i < 6; i++)
            put_byte(8'h41, i == 5);
        // ends on a miss: two codes for the last byte
        put_byte(8'h12, 1'b0);
        put_byte(8'h34, 1'b1);
        put_byte(8'h55, 1'b0);
        put_byte(8'hAA, 1'b0);
        put_byte(8'h55, 1'b0);
        put_byte(8'hAA, 1'b0);
        put_byte(8'h55, 1'b1);
        put_byte(8'h80, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(8'h01, 1'b0);
        put_byte(8'hFE, 1'b1);

        // long stream: many dictionary entries and probe collisions
        send_stream(LONG_STREAM, SRC_FULL);

        while (random_sent < RANDOM_BYTES)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 40);
            src = source_t'($urandom_range(0, 2));
            send_stream(len, src);
            random_sent += len;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d streams and checked %0d codes;",
                 bytes_in, streams_done, codes_out);
        $display("%0d bytes arrived with the dictionary full.", full_bytes);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
